// ===== sv/bffa_pkg.sv =====
// shared types and constants of the first-fit bitmap allocator
// no dependencies; imported by bffa_byte_scan, bitmap_first_fit_allocator and the testbench
`default_nettype none

package bffa_pkg;

    // bitmap geometry
    localparam int MAX_BYTES      = 64;
    localparam int UNITS_PER_BYTE = 8;
    localparam int BYTE_AW        = $clog2(MAX_BYTES);
    localparam int BIT_AW         = $clog2(UNITS_PER_BYTE);
    localparam int START_W        = BYTE_AW + BIT_AW;
    localparam int PTR_W          = BYTE_AW + 1;

    // field widths
    localparam int CFG_W   = 7;
    localparam int NEED_W  = 10;
    localparam int BYTE_W  = 8;

    // request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_DONE
    } state_t;

    // free-run tracker carried from byte to byte during a scan
    typedef struct packed {
        logic               hit;
        logic [NEED_W-1:0]  len;
        logic [START_W-1:0] start;
    } run_t;

endpackage

`default_nettype wire

// ===== sv/bffa_byte_scan.sv =====
// run tracker for one bitmap byte: walks its eight units from msb to lsb
// depends on bffa_pkg for widths and the run_t struct
`default_nettype none

module bffa_byte_scan (
    input  wire logic [bffa_pkg::BYTE_W-1:0]  byte_data,
    input  wire logic [bffa_pkg::BYTE_AW-1:0] byte_idx,
    input  wire logic [bffa_pkg::NEED_W-1:0]  need,
    input  wire bffa_pkg::run_t                run_in,
    output      bffa_pkg::run_t                run_out
);
    import bffa_pkg::*;

    logic [UNITS_PER_BYTE-1:0] free_at;
    logic [UNITS_PER_BYTE-1:0] hit_at;
    logic [NEED_W-1:0]         len_at   [UNITS_PER_BYTE];
    logic [START_W-1:0]        start_at [UNITS_PER_BYTE];

    // run length and start at every unit of the byte, worked out side by side
    // msb is the lowest unit; only the last used position is carried along
    always_comb
    begin
        logic              seen_used;
        logic [BIT_AW-1:0] last_used;
        seen_used = 1'b0;
        last_used = '0;
        for (int i = 0; i < UNITS_PER_BYTE; i++)
        begin
            free_at[i] = !byte_data[UNITS_PER_BYTE-1-i];
            if (!free_at[i])
            begin
                seen_used = 1'b1;
                last_used = BIT_AW'(i);
            end
            if (!free_at[i])
            begin
                len_at[i]   = '0;
                start_at[i] = run_in.start;
            end
            else if (seen_used)
            begin
                // run began inside this byte, just after the last used unit
                len_at[i]   = NEED_W'(BIT_AW'(i) - last_used);
                start_at[i] = {byte_idx, last_used + BIT_AW'(1)};
            end
            else
            begin
                // run carried in from earlier bytes, or starting at this byte's msb
                len_at[i]   = run_in.len + NEED_W'(i + 1);
                start_at[i] = (run_in.len == '0) ? {byte_idx, BIT_AW'(0)} : run_in.start;
            end
            hit_at[i] = !run_in.hit && free_at[i] && (len_at[i] == need);
        end
    end

    // first unit that completes the run wins
    always_comb
    begin
        run_out.hit   = 1'b0;
        run_out.len   = len_at[UNITS_PER_BYTE-1];
        run_out.start = start_at[UNITS_PER_BYTE-1];
        for (int i = UNITS_PER_BYTE - 1; i >= 0; i--)
        begin
            if (hit_at[i])
            begin
                run_out.hit   = 1'b1;
                run_out.len   = len_at[i];
                run_out.start = start_at[i];
            end
        end
        if (run_in.hit)
        begin
            run_out = run_in;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bitmap_first_fit_allocator.sv =====
// top level of the first-fit bitmap allocator: sequencer, bitmap memory, handshakes
// depends on bffa_pkg and bffa_byte_scan
`default_nettype none

// Allocation bitmap of 64 bytes (512 units, msb of a byte is its lowest unit, 1 = used)
// held in a synchronous memory with a registered read and a valid bit per byte,
// so reset frees every unit at once with no clearing pass. Words are taken one at a
// time. A byte-write word, or an allocate word that fails its length check, goes
// straight to the done state and its result is registered. Otherwise the scan reads
// one bitmap byte a cycle through a single read port, ending early at the first fit,
// then the run is marked by a pipelined read-modify-write of every byte it touches,
// then the result is registered. bytes_in_use above 64 is treated as 64; the user
// must write it only while the block is idle, and the block does not enforce this.
module bitmap_first_fit_allocator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [bffa_pkg::CFG_W-1:0]    cfg_wr_data,
    // request channel
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic                          req_type,
    input  wire logic [bffa_pkg::NEED_W-1:0]   req_units,
    input  wire logic [bffa_pkg::BYTE_AW-1:0]  byte_index,
    input  wire logic [bffa_pkg::BYTE_W-1:0]   byte_value,
    // result channel
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic                          found,
    output      logic [bffa_pkg::START_W-1:0]  start_unit
);
    import bffa_pkg::*;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MAX_BYTES);

    // registers
    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     cfg_bytes_reg;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic                 data_vld_reg, data_vld_next;
    logic [BYTE_AW-1:0]   data_byte_reg, data_byte_next;
    logic [NEED_W-1:0]    need_reg, need_next;
    run_t                 run_reg, run_next;
    logic [START_W-1:0]   end_unit_reg, end_unit_next;
    logic                 res_found_reg, res_found_next;
    logic [START_W-1:0]   res_start_reg, res_start_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 found_reg, found_next;
    logic [START_W-1:0]   start_unit_reg, start_unit_next;

    // bitmap memory and per-byte valid bits
    logic [BYTE_W-1:0]    bitmap_mem [MAX_BYTES];
    logic [MAX_BYTES-1:0] entry_vld_reg;
    logic [BYTE_W-1:0]    rd_data_reg;
    logic                 rd_vld_reg;
    logic [BYTE_W-1:0]    rd_byte;

    logic                 mem_we;
    logic [BYTE_AW-1:0]   mem_waddr;
    logic [BYTE_W-1:0]    mem_wdata;

    // derived control
    logic                 in_acc;
    logic                 out_free;
    logic [PTR_W-1:0]     nbytes;
    logic [NEED_W-1:0]    total_units;
    logic [BYTE_AW-1:0]   last_byte;
    logic [BYTE_AW-1:0]   end_byte;
    logic                 scan_issue;
    logic                 mark_issue;
    logic                 bad_need;
    logic [BYTE_W-1:0]    mark_mask;
    logic [NEED_W-1:0]    end_sum;
    run_t                 scan_out;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // active byte count, clamped to the bitmap size
    assign nbytes      = (cfg_bytes_reg > CFG_W'(MAX_BYTES)) ? PTR_W'(MAX_BYTES)
                                                             : PTR_W'(cfg_bytes_reg);
    assign total_units = NEED_W'({nbytes, BIT_AW'(0)});
    assign last_byte   = BYTE_AW'(nbytes - PTR_W'(1));
    assign end_byte    = end_unit_reg[START_W-1:BIT_AW];
    assign bad_need    = (req_units == '0) || (req_units > total_units);

    assign scan_issue  = (state_reg == ST_SCAN) && (ptr_reg < nbytes);
    assign mark_issue  = (state_reg == ST_MARK) && (ptr_reg <= PTR_W'(end_byte));

    // entries never written since reset read as their reset value of zero
    assign rd_byte = rd_vld_reg ? rd_data_reg : '0;

    // byte tracker
    bffa_byte_scan u_byte_scan (
        .byte_data (rd_byte),
        .byte_idx  (data_byte_reg),
        .need      (need_reg),
        .run_in    (run_reg),
        .run_out   (scan_out)
    );

    // marks for the byte being written back
    always_comb
    begin
        logic [START_W-1:0] unit;
        mark_mask = '0;
        for (int i = 0; i < UNITS_PER_BYTE; i++)
        begin
            unit = {data_byte_reg, BIT_AW'(i)};
            mark_mask[UNITS_PER_BYTE-1-i] = (unit >= run_reg.start) && (unit <= end_unit_reg);
        end
    end

    assign end_sum = NEED_W'(scan_out.start) + need_reg - NEED_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (req_type == REQ_WRITE || bad_need)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (data_vld_reg)
                begin
                    if (scan_out.hit)
                    begin
                        state_next = ST_MARK;
                    end
                    else if (data_byte_reg == last_byte)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MARK:
            begin
                if (data_vld_reg && data_byte_reg == end_byte)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        ptr_next        = ptr_reg;
        data_vld_next   = 1'b0;
        data_byte_next  = data_byte_reg;
        need_next       = need_reg;
        run_next        = run_reg;
        end_unit_next   = end_unit_reg;
        res_found_next  = res_found_reg;
        res_start_next  = res_start_reg;
        mem_we          = 1'b0;
        mem_waddr       = data_byte_reg;
        mem_wdata       = rd_byte | mark_mask;
        out_valid_next  = out_valid_reg && out_stall;
        found_next      = found_reg;
        start_unit_next = start_unit_reg;
        in_stall        = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    need_next      = req_units;
                    run_next       = '0;
                    ptr_next       = '0;
                    res_found_next = 1'b0;
                    res_start_next = '0;
                    if (req_type == REQ_WRITE)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = byte_index;
                        mem_wdata = byte_value;
                    end
                end
            end
            ST_SCAN:
            begin
                // keep one read in flight while the scan goes on
                if (scan_issue && state_next == ST_SCAN)
                begin
                    ptr_next       = ptr_reg + PTR_W'(1);
                    data_vld_next  = 1'b1;
                    data_byte_next = ptr_reg[BYTE_AW-1:0];
                end
                if (data_vld_reg)
                begin
                    run_next = scan_out;
                    if (scan_out.hit)
                    begin
                        ptr_next       = PTR_W'(scan_out.start[START_W-1:BIT_AW]);
                        end_unit_next  = end_sum[START_W-1:0];
                        res_found_next = 1'b1;
                        res_start_next = scan_out.start;
                    end
                end
            end
            ST_MARK:
            begin
                // pipelined read-modify-write over the run's bytes
                if (mark_issue)
                begin
                    ptr_next       = ptr_reg + PTR_W'(1);
                    data_vld_next  = 1'b1;
                    data_byte_next = ptr_reg[BYTE_AW-1:0];
                end
                if (data_vld_reg)
                begin
                    mem_we = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    found_next      = res_found_reg;
                    start_unit_next = res_start_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_bytes_reg <= CFG_RESET;
            data_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            entry_vld_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            data_vld_reg  <= data_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cfg_bytes_reg <= cfg_wr_data;
            end
            if (mem_we)
            begin
                entry_vld_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        data_byte_reg  <= data_byte_next;
        need_reg       <= need_next;
        run_reg        <= run_next;
        end_unit_reg   <= end_unit_next;
        res_found_reg  <= res_found_next;
        res_start_reg  <= res_start_next;
        found_reg      <= found_next;
        start_unit_reg <= start_unit_next;
    end

    // bitmap memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= bitmap_mem[ptr_reg[BYTE_AW-1:0]];
        rd_vld_reg  <= entry_vld_reg[ptr_reg[BYTE_AW-1:0]];
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign start_unit = start_unit_reg;

endmodule

`default_nettype wire

// ===== sim/bitmap_first_fit_allocator_test.sv =====
// self-checking testbench for the first-fit bitmap allocator: opening table, then random words
// over several bytes_in_use settings; depends on bffa_pkg and bitmap_first_fit_allocator
module bitmap_first_fit_allocator_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bffa_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 9;
    localparam int N_OPENING       = 22;
    localparam int N_PHASES        = 10;
    localparam int WORDS_PER_PHASE = 85;
    localparam int LONG_HOLD       = 300;
    localparam int TAIL_CYCLES     = 150;
    localparam int STUCK_LIMIT     = 2000;
    localparam int PRINT_LIMIT     = 100;
    localparam int NEED_MAX        = (1 << NEED_W) - 1;

    typedef struct packed {
        logic               rtype;
        logic [NEED_W-1:0]  need;
        logic [BYTE_AW-1:0] idx;
        logic [BYTE_W-1:0]  val;
    } request_t;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
    } grant_t;

    typedef struct packed {
        request_t req;
        logic     typed;
        grant_t   want;
    } plan_row_t;

    // block ports
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_wr_en    = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data  = '0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic               req_type     = REQ_ALLOC;
    logic [NEED_W-1:0]  req_units    = '0;
    logic [BYTE_AW-1:0] byte_index   = '0;
    logic [BYTE_W-1:0]  byte_value   = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic               found;
    logic [START_W-1:0] start_unit;

    // predictor state and bookkeeping
    logic [BYTE_W-1:0]  bitmap_copy [MAX_BYTES] = '{default: '0};
    logic [CFG_W-1:0]   search_bytes = 7'd64;
    grant_t             pending_grants [$];
    int                 mismatches    = 0;
    int                 idle_cycles   = 0;
    int                 hold_left     = 0;
    int                 stall_pct     = 25;
    int                 send_gap_pct  = 25;
    logic               long_hold_req = 1'b0;
    int                 n_words       = 0;
    int                 n_placed      = 0;
    int                 n_refused     = 0;
    int                 n_writes      = 0;
    int                 n_settings    = 1;

    // opening table, run at the reset setting of 64 bytes
    plan_row_t opening_plan [N_OPENING] = '{
        '{'{REQ_ALLOC, 10'd0,    6'd63, 8'hFF}, 1'b1, '{1'b0, 9'd0}},
        '{'{REQ_ALLOC, 10'd1023, 6'd0,  8'h00}, 1'b1, '{1'b0, 9'd0}},
        '{'{REQ_ALLOC, 10'd513,  6'd21, 8'h5A}, 1'b1, '{1'b0, 9'd0}},
        '{'{REQ_ALLOC, 10'd1,    6'd0,  8'h00}, 1'b1, '{1'b1, 9'd0}},
        '{'{REQ_ALLOC, 10'd8,    6'd0,  8'h00}, 1'b1, '{1'b1, 9'd1}},
        '{'{REQ_WRITE, 10'd0,    6'd0,  8'h00}, 1'b1, '{1'b0, 9'd0}},
        '{'{REQ_ALLOC, 10'd512,  6'd0,  8'h00}, 1'b0, '{1'b0, 9'd0}},
        '{'{REQ_WRITE, 10'd1023, 6'd1,  8'h00}, 1'b1, '{1'b0, 9'd0}},
        '{'{REQ_ALLOC, 10'd512,  6'd0,  8'h00}, 1'b1, '{1'b1, 9'd0}},
        '{'{REQ_ALLOC, 10'd1,    6'd0,  8'h00}, 1'b1, '{1'b0, 9'd0}},
        '{'{REQ_WRITE, 10'd0,    6'd63, 8'h00}, 1'b1, '{1'b0, 9'd0}},
        '{'{REQ_ALLOC, 10'd9,    6'd0,  8'h00}, 1'b0, '{1'b0, 9'd0}},
        '{'{REQ_ALLOC, 10'd8,    6'd0,  8'h00}, 1'b0, '{1'b0, 9'd0}},
        '{'{REQ_WRITE, 10'd0,    6'd0,  8'h55}, 1'b1, '{1'b0, 9'd0}},
        '{'{REQ_ALLOC, 10'd2,    6'd0,  8'h00}, 1'b0, '{1'b0, 9'd0}},
        '{'{REQ_ALLOC, 10'd1,    6'd0,  8'h00}, 1'b0, '{1'b0, 9'd0}},
        '{'{REQ_WRITE, 10'd0,    6'd32, 8'hF0}, 1'b1, '{1'b0, 9'd0}},
        '{'{REQ_WRITE, 10'd0,    6'd33, 8'h7F}, 1'b1, '{1'b0, 9'd0}},
        '{'{REQ_ALLOC, 10'd5,    6'd0,  8'h00}, 1'b0, '{1'b0, 9'd0}},
        '{'{REQ_WRITE, 10'd1023, 6'd62, 8'hAA}, 1'b1, '{1'b0, 9'd0}},
        '{'{REQ_ALLOC, 10'd1,    6'd63, 8'hFF}, 1'b0, '{1'b0, 9'd0}},
        '{'{REQ_WRITE, 10'd0,    6'd5,  8'h80}, 1'b1, '{1'b0, 9'd0}}
    };

    // register settings per phase; phases 7 and 8 are drawn at random
    logic [CFG_W-1:0] setting_plan [N_PHASES] = '{
        7'd1, 7'd0, 7'd127, 7'd65, 7'd8, 7'd64, 7'd3, 7'd0, 7'd0, 7'd64
    };

    bitmap_first_fit_allocator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .req_units    (req_units),
        .byte_index   (byte_index),
        .byte_value   (byte_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .start_unit   (start_unit)
    );

    // clock
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // applies a byte write to the copied bitmap, or runs a first-fit search over it and marks the run when one is found
    function automatic grant_t first_fit_outcome(request_t w);
        grant_t r;
        int     nbytes;
        int     total;
        int     run_start;
        int     run_len;
        int     u;
        logic   hit;
        r = '0;
        if (w.rtype == REQ_WRITE)
        begin
            bitmap_copy[w.idx] = w.val;
            return r;
        end
        nbytes = (search_bytes > MAX_BYTES) ? MAX_BYTES : int'(search_bytes);
        total = nbytes * UNITS_PER_BYTE;
        if (w.need == 0 || int'(w.need) > total)
            return r;
        run_start = 0;
        run_len = 0;
        hit = 1'b0;
        for (u = 0; u < total && !hit; u++)
        begin
            if (!bitmap_copy[u / UNITS_PER_BYTE][UNITS_PER_BYTE - 1 - u % UNITS_PER_BYTE])
            begin
                if (run_len == 0)
                    run_start = u;
                run_len++;
                if (run_len == int'(w.need))
                    hit = 1'b1;
            end
            else
                run_len = 0;
        end
        if (hit)
        begin
            for (u = run_start; u < run_start + int'(w.need); u++)
                bitmap_copy[u / UNITS_PER_BYTE][UNITS_PER_BYTE - 1 - u % UNITS_PER_BYTE] = 1'b1;
            r.found = 1'b1;
            r.start = START_W'(run_start);
        end
        return r;
    endfunction

    // random word: mostly allocations that fit the searched space, plus byte writes, mostly to its bytes
    function automatic request_t draw_request();
        request_t w;
        int       nbytes;
        int       total;
        int       pick;
        nbytes = (search_bytes > MAX_BYTES) ? MAX_BYTES : int'(search_bytes);
        total = nbytes * UNITS_PER_BYTE;
        w.rtype = ($urandom_range(0, 99) < 55) ? REQ_ALLOC : REQ_WRITE;
        w.need = NEED_W'($urandom());
        w.idx = BYTE_AW'($urandom());
        w.val = BYTE_W'($urandom());
        pick = $urandom_range(0, 99);
        if (w.rtype == REQ_ALLOC)
        begin
            if (pick < 5)
                w.need = '0;
            else if (pick < 12)
                w.need = NEED_W'($urandom_range(total + 1, NEED_MAX));
            else if (pick < 15 && total > 0)
                w.need = NEED_W'(total);
            else if (pick < 28)
                w.need = NEED_W'($urandom_range(1, (total > 0) ? total : 1));
            else
                w.need = NEED_W'($urandom_range(1, 12));
        end
        else
        begin
            if (pick < 80 && nbytes > 0)
                w.idx = BYTE_AW'($urandom_range(0, nbytes - 1));
            pick = $urandom_range(0, 99);
            if (pick < 40)
                w.val = '0;
            else if (pick < 55)
                w.val = '1;
        end
        return w;
    endfunction

    // one line per mismatch, printing capped
    task automatic report_mismatch(string what, int got, int want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // offer one word, record its expected result once taken, then maybe leave a gap
    task automatic offer_word(request_t w, logic typed, grant_t want);
        grant_t outcome;
        in_valid     <= 1'b1;
        req_type     <= w.rtype;
        req_units    <= w.need;
        byte_index   <= w.idx;
        byte_value   <= w.val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        outcome = first_fit_outcome(w);
        pending_grants.push_back(typed ? want : outcome);
        n_words++;
        if (w.rtype == REQ_WRITE)
            n_writes++;
        else if (outcome.found)
            n_placed++;
        else
            n_refused++;
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    // stop offering and wait until every result is back
    task automatic await_results();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    // register write, only while the block is idle
    task automatic write_bytes_in_use(logic [CFG_W-1:0] setting);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= setting;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        search_bytes = setting;
        n_settings++;
    endtask

    // receiver: random stall bursts plus one long hold on request
    always @(posedge clk)
    begin : result_receiver
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (long_hold_req)
        begin
            long_hold_req <= 1'b0;
            hold_left     <= LONG_HOLD - 1;
            out_stall     <= 1'b1;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            hold_left <= $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin : result_check
        grant_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_grants.size() == 0)
                report_mismatch("unexpected result word, found", found, 0);
            else
            begin
                want = pending_grants.pop_front();
                if (found !== want.found)
                    report_mismatch("found", found, want.found);
                if (start_unit !== want.start)
                    report_mismatch("start_unit", start_unit, want.start);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin : stimulus
        int               p;
        int               k;
        logic [CFG_W-1:0] setting;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening table at the reset setting
        for (k = 0; k < N_OPENING; k++)
            offer_word(opening_plan[k].req, opening_plan[k].typed, opening_plan[k].want);

        // random phases, one register setting each
        for (p = 0; p < N_PHASES; p++)
        begin
            await_results();
            if (p == 7)
                setting = CFG_W'($urandom_range(1, MAX_BYTES));
            else if (p == 8)
                setting = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
            else
                setting = setting_plan[p];
            write_bytes_in_use(setting);
            if (p == N_PHASES - 1)
            begin
                stall_pct    = 0;
                send_gap_pct = 0;
            end
            else
            begin
                stall_pct    = 15 * $urandom_range(0, 3);
                send_gap_pct = 15 * $urandom_range(0, 3);
            end
            for (k = 0; k < WORDS_PER_PHASE; k++)
            begin
                // receiver holds off while words keep coming, so the input backs up
                if (p == 2 && k == 10)
                    long_hold_req <= 1'b1;
                // sender pauses until everything is back
                if (p == 5 && k == WORDS_PER_PHASE / 2)
                    await_results();
                offer_word(draw_request(), 1'b0, '0);
            end
        end

        await_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("covered %0d words under %0d bytes_in_use settings (zero, 1, 64 and above 64)",
                 n_words, n_settings);
        $display("allocations placed %0d, refused %0d, byte writes %0d, mismatches %0d",
                 n_placed, n_refused, n_writes, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
